// ----- design/cwl_pkg.sv -----
package cwl_pkg;

  localparam int WORD_W        = 32;
  localparam int POSITION_W    = 6;
  localparam int ENTRY_COUNT_W = 7;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [WORD_W-1:0] SENTINEL = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                req_type;
    logic [POSITION_W-1:0]     position;
    logic signed [WORD_W-1:0]  word_in;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  word_out;
    logic [1:0]                status;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } rsp_t;

  // Per-cell controls decoded at the top level.
  typedef struct packed {
    logic wr;
    logic shift;
    logic load;
    logic rd_shift;
  } cwl_cell_ctl_t;

endpackage

// ----- design/cwl_cell.sv -----
module cwl_cell import cwl_pkg::*; (
  input  logic                     clk,
  input  cwl_cell_ctl_t            ctl,
  input  logic signed [WORD_W-1:0] word,
  input  logic signed [WORD_W-1:0] next_entry,
  input  logic signed [WORD_W-1:0] next_rd,
  output logic signed [WORD_W-1:0] entry,
  output logic signed [WORD_W-1:0] rd
);

  // A write stores the request word; otherwise a delete pulls the neighbor's word down into this cell.
  always_ff @(posedge clk) begin
    priority if (ctl.wr) begin
      entry <= word;
    end else if (ctl.shift) begin
      entry <= next_entry;
    end else begin
      entry <= entry;
    end
  end

  // The read chain carries a captured word one cell per cycle toward cell zero.
  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      rd <= entry;
    end else if (ctl.rd_shift) begin
      rd <= next_rd;
    end else begin
      rd <= rd;
    end
  end

endmodule

// ----- design/compacting_word_list.sv -----
// Ordered list of signed 32-bit words held in a chain of DEPTH cells, one word per cell.
// Append, set and delete, and any refused request, are answered directly: a delete moves
// every later cell down one place at once. A get at position p captures the word in
// its cell's read register and then passes it down the read chain one cell per cycle
// until it reaches cell zero. A new request waits while a get is in progress, and also
// while a result is held on a stalled output.
module compacting_word_list import cwl_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  logic req_valid,
  output logic req_stall,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_stall
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                    state;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           cnt_next;
  logic [POSITION_W-1:0]   rcnt;
  logic                    rsp_valid_next;

  logic signed [WORD_W-1:0] entry_q [DEPTH];
  logic signed [WORD_W-1:0] rd_q    [DEPTH];
  cwl_cell_ctl_t            ctl     [DEPTH];

  logic            out_free;
  logic            acc;
  logic [CMPW-1:0] pos_c;
  logic [CMPW-1:0] cnt_c;
  logic            in_range;
  logic            not_full;
  logic            do_append;
  logic            do_set;
  logic            do_get;
  logic            do_delete;
  logic            read_done;
  logic [1:0]      status_now;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state == S_READ) || !out_free;
  assign acc       = req_valid && !req_stall;

  assign pos_c    = CMPW'(req.position);
  assign cnt_c    = CMPW'(cnt);
  assign in_range = pos_c < cnt_c;
  assign not_full = cnt < CW'(DEPTH);

  assign do_append = acc && (req.req_type == OP_APPEND) && not_full;
  assign do_set    = acc && (req.req_type == OP_SET) && in_range;
  assign do_get    = acc && (req.req_type == OP_GET) && in_range;
  assign do_delete = acc && (req.req_type == OP_DELETE) && in_range;

  assign read_done = (state == S_READ) && (rcnt == '0) && out_free;

  // A held beat stays until taken; a new result is loaded on any request but an in-range get, or a finished get.
  assign rsp_valid_next = (rsp_valid && rsp_stall) || (acc && !do_get) || read_done;

  always_comb begin
    cnt_next = cnt;
    if (do_append) begin
      cnt_next = cnt + CW'(1);
    end else if (do_delete) begin
      cnt_next = cnt - CW'(1);
    end
  end

  always_comb begin
    status_now = ST_OK;
    unique case (req.req_type)
      OP_APPEND: if (!not_full) status_now = ST_FULL;
      OP_SET, OP_GET, OP_DELETE: if (!in_range) status_now = ST_INDEX;
      default: status_now = ST_OK;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0]   IDX_CNT = CW'(i);
    localparam logic [CMPW-1:0] IDX_POS = CMPW'(i);

    logic signed [WORD_W-1:0] nbr_entry;
    logic signed [WORD_W-1:0] nbr_rd;

    if (i == DEPTH - 1) begin : g_top
      assign nbr_entry = SENTINEL;
      assign nbr_rd    = SENTINEL;
    end else begin : g_mid
      assign nbr_entry = entry_q[i+1];
      assign nbr_rd    = rd_q[i+1];
    end

    assign ctl[i].wr       = (do_append && (cnt == IDX_CNT)) || (do_set && (pos_c == IDX_POS));
    assign ctl[i].shift    = do_delete && (IDX_POS >= pos_c);
    assign ctl[i].load     = do_get && (pos_c == IDX_POS);
    assign ctl[i].rd_shift = (state == S_READ) && (rcnt != '0);

    cwl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .word       (req.word_in),
      .next_entry (nbr_entry),
      .next_rd    (nbr_rd),
      .entry      (entry_q[i]),
      .rd         (rd_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cnt <= cnt_next;
            if (do_get) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (read_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_get) begin
      rcnt <= req.position;
    end else if ((state == S_READ) && (rcnt != '0)) begin
      rcnt <= rcnt - POSITION_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !do_get) begin
      rsp.word_out    <= SENTINEL;
      rsp.status      <= status_now;
      rsp.entry_count <= ENTRY_COUNT_W'(cnt_next);
    end else if (read_done) begin
      rsp.word_out    <= rd_q[0];
      rsp.status      <= ST_OK;
      rsp.entry_count <= ENTRY_COUNT_W'(cnt);
    end
  end

endmodule
